// File: design/gpg_pkg.sv
// ----------------------------------------------------------------------------
// gpg_pkg: shared constants for the GF(p) polynomial gcd block
// Field widths, default sizing and the modular multiply step width.
// ----------------------------------------------------------------------------
package gpg_pkg;

	// Default highest power of x held in the coefficient stores
	localparam int MAX_DEGREE_DEF = 32;

	// Coefficient and modulus width
	localparam int COEF_W = 16;

	// Width of the index fields on the ports
	localparam int IDX_PORT_W = 6;

	// Modulus register reset value and smallest usable modulus
	localparam logic [COEF_W-1:0] MOD_RESET = 16'd13;
	localparam logic [COEF_W-1:0] MOD_MIN   = 16'd2;

	// Product width and product bits reduced per cycle in the multiplier
	localparam int PROD_W          = 2 * COEF_W;
	localparam int MM_BITS_PER_CYC = 2;

endpackage

// File: design/gpg_coef_ram.sv
// ----------------------------------------------------------------------------
// gpg_coef_ram: coefficient store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gpg_coef_ram #(
	parameter int DEPTH = gpg_pkg::MAX_DEGREE_DEF + 1,
	parameter int AW    = $clog2(DEPTH),
	parameter int W     = gpg_pkg::COEF_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	// Write, then register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/gpg_mulmod.sv
// ----------------------------------------------------------------------------
// gpg_mulmod: modular multiplier
// Registers a*b, then reduces the product modulo p MM_BITS_PER_CYC bits per
// cycle by restoring shift-and-subtract. done pulses for one cycle; result then
// holds until the next start.
// ----------------------------------------------------------------------------
module gpg_mulmod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gpg_pkg::COEF_W-1:0]  op_a,
	input  logic [gpg_pkg::COEF_W-1:0]  op_b,
	input  logic [gpg_pkg::COEF_W-1:0]  modp,
	output logic                        done,
	output logic [gpg_pkg::COEF_W-1:0]  result
);

	localparam int W      = gpg_pkg::COEF_W;
	localparam int PW     = gpg_pkg::PROD_W;
	localparam int BPC    = gpg_pkg::MM_BITS_PER_CYC;
	localparam int N_STEP = PW / BPC;
	localparam int CW     = $clog2(N_STEP);

	logic [PW-1:0] prod_q, prod_nx;
	logic [W-1:0]  r_q, r_nx, p_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	// Shift the next product bits into the partial remainder
	always_comb begin
		logic [W:0] t;
		r_nx    = r_q;
		prod_nx = prod_q;
		t       = '0;
		for (int i = 0; i < BPC; i++) begin
			t = {r_nx, prod_nx[PW-1]};
			if (t >= {1'b0, p_q}) begin
				t = t - {1'b0, p_q};
			end
			r_nx    = t[W-1:0];
			prod_nx = prod_nx << 1;
		end
	end

	// Load on start, advance while busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			prod_q <= '0;
			r_q    <= '0;
			p_q    <= gpg_pkg::MOD_MIN;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				prod_q <= PW'(op_a) * PW'(op_b);
				p_q    <= modp;
				r_q    <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				prod_q <= prod_nx;
				r_q    <= r_nx;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == CW'(N_STEP - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

// File: design/gf_p_polynomial_gcd.sv
// ----------------------------------------------------------------------------
// gf_p_polynomial_gcd: gcd of two polynomials over GF(p)
// Loads two coefficient stores, runs Euclid's algorithm in place and emits
// the monic gcd from degree 0 upward.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one coefficient per item. poly_select
//   picks the polynomial, coef_index the power of x; an index above
//   MAX_DEGREE stores nothing. end_of_load starts the gcd run after the item.
//   Each stored coefficient is reduced mod p by the modular multiplier (one
//   product, then 2 bits per cycle) before the next load item is taken.
//   Output channel (out_valid/out_stall): one item per gcd coefficient, last
//   on the leading one; both polynomials zero gives a single item with error.
//   A run does 2*(MAX_DEGREE+1) modular multiplies for the initial reduction,
//   up to 32 per inverse, one per quotient digit and per product term and
//   one per output coefficient, so it grows with the square of the degrees.
//   Both stores live in single-port-read RAMs; after each run and after
//   reset a clearing pass over the MAX_DEGREE+1 entries zeroes them, with
//   in_stall held high. A stalled output item holds; the block keeps computing
//   the next coefficient and waits only when that one is ready.
//   The user writes modulus through cfg_wr_en/cfg_wr_data only while idle;
//   the block does not enforce it. Reset value 13, values below 2 act as 2.
// ----------------------------------------------------------------------------
module gf_p_polynomial_gcd #(
	parameter int MAX_DEGREE = gpg_pkg::MAX_DEGREE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [gpg_pkg::COEF_W-1:0]      cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            poly_select,
	input  logic [gpg_pkg::IDX_PORT_W-1:0]  coef_index,
	input  logic [gpg_pkg::COEF_W-1:0]      coef_value,
	input  logic                            end_of_load,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [gpg_pkg::IDX_PORT_W-1:0]  out_index,
	output logic [gpg_pkg::COEF_W-1:0]      out_value,
	output logic                            last,
	output logic                            error
);

	localparam int W     = gpg_pkg::COEF_W;
	localparam int PW    = gpg_pkg::IDX_PORT_W;
	localparam int DEPTH = MAX_DEGREE + 1;
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_DEGREE);

	typedef enum logic [25:0] {
		S_CLEAR    = 26'h0000001,
		S_LOAD     = 26'h0000002,
		S_LMUL     = 26'h0000004,
		S_PRD      = 26'h0000008,
		S_PMA      = 26'h0000010,
		S_PWA      = 26'h0000020,
		S_PWB      = 26'h0000040,
		S_DECIDE   = 26'h0000080,
		S_LOOP     = 26'h0000100,
		S_INV_RD   = 26'h0000200,
		S_INV_LD   = 26'h0000400,
		S_INV_CHK  = 26'h0000800,
		S_INV_WACC = 26'h0001000,
		S_INV_WSQ  = 26'h0002000,
		S_INV_END  = 26'h0004000,
		S_DIV_TOP  = 26'h0008000,
		S_DIV_Q    = 26'h0010000,
		S_DIV_QW   = 26'h0020000,
		S_DIV_RD   = 26'h0040000,
		S_DIV_M    = 26'h0080000,
		S_DIV_MW   = 26'h0100000,
		S_DIV_END  = 26'h0200000,
		S_OUT_RD   = 26'h0400000,
		S_OUT_M    = 26'h0800000,
		S_OUT_MW   = 26'h1000000,
		S_OUT_PUT  = 26'h2000000
	} state_t;

	state_t state_q;

	logic [W-1:0]     mod_q, p_eff;
	logic [IDX_W-1:0] idx_q, da_q, db_q, k_q, j_q, ld_idx_q, rem_deg_q;
	logic             asel_q, fin_q, err_q, anz_q, bnz_q, rem_nz_q;
	logic             ld_sel_q, ld_eol_q;
	logic [W-1:0]     tmp_q, q_q, inv_q, acc_q, base_q, e_q;
	logic             out_valid_q;

	// RAM and multiplier hookup
	logic             we0, we1;
	logic [IDX_W-1:0] waddr, ra_a, ra_b, raddr0, raddr1;
	logic [W-1:0]     wdata, rd0, rd1, rd_a, rd_b;
	logic             mm_start, mm_done;
	logic [W-1:0]     mm_a, mm_b, mm_res;
	logic [W:0]       sub_w;
	logic [W-1:0]     sub_res;
	logic             in_take, in_rng, out_free, out_last;

	assign p_eff    = (mod_q < gpg_pkg::MOD_MIN) ? gpg_pkg::MOD_MIN : mod_q;
	assign in_stall = (state_q != S_LOAD);
	assign in_take  = in_valid && (state_q == S_LOAD);
	assign in_rng   = (coef_index <= PW'(MAX_DEGREE));
	assign out_free = !out_valid_q || !out_stall;
	assign out_last = err_q || (idx_q == da_q);
	assign out_valid = out_valid_q;

	// Map the working pair (A, B) onto the two physical stores
	assign raddr0 = asel_q ? ra_b : ra_a;
	assign raddr1 = asel_q ? ra_a : ra_b;
	assign rd_a   = asel_q ? rd1 : rd0;
	assign rd_b   = asel_q ? rd0 : rd1;

	// a[j] - q*b[j-k] mod p, inputs already below p
	assign sub_w   = {1'b0, tmp_q} + {1'b0, p_eff} - {1'b0, mm_res};
	assign sub_res = (sub_w >= {1'b0, p_eff}) ? W'(sub_w - {1'b0, p_eff}) : sub_w[W-1:0];

	// Read addresses
	always_comb begin
		ra_a = idx_q;
		ra_b = idx_q;
		unique case (state_q)
			S_INV_RD: begin
				ra_a = da_q;
				ra_b = db_q;
			end
			S_DIV_TOP: begin
				ra_a = db_q + k_q;
			end
			S_DIV_RD: begin
				ra_a = j_q;
				ra_b = j_q - k_q;
			end
			default: ;
		endcase
	end

	// Write port
	always_comb begin
		we0   = 1'b0;
		we1   = 1'b0;
		waddr = idx_q;
		wdata = mm_res;
		unique case (state_q)
			S_CLEAR: begin
				we0   = 1'b1;
				we1   = 1'b1;
				wdata = '0;
			end
			S_LMUL: begin
				waddr = ld_idx_q;
				we0   = mm_done && !ld_sel_q;
				we1   = mm_done && ld_sel_q;
			end
			S_PWA: begin
				we0 = mm_done;
			end
			S_PWB: begin
				we1 = mm_done;
			end
			S_DIV_MW: begin
				waddr = j_q;
				wdata = sub_res;
				we0   = mm_done && !asel_q;
				we1   = mm_done && asel_q;
			end
			default: ;
		endcase
	end

	// Multiplier operands
	always_comb begin
		mm_start = 1'b0;
		mm_a     = rd_a;
		mm_b     = W'(1);
		unique case (state_q)
			S_LOAD: begin
				mm_start = in_take && in_rng;
				mm_a     = coef_value;
			end
			S_PMA: begin
				mm_start = 1'b1;
			end
			S_PWA: begin
				mm_start = mm_done;
				mm_a     = tmp_q;
			end
			S_INV_CHK: begin
				mm_start = 1'b1;
				mm_a     = e_q[0] ? acc_q : base_q;
				mm_b     = base_q;
			end
			S_INV_WACC: begin
				mm_start = mm_done;
				mm_a     = base_q;
				mm_b     = base_q;
			end
			S_DIV_Q, S_OUT_M: begin
				mm_start = 1'b1;
				mm_b     = inv_q;
			end
			S_DIV_M: begin
				mm_start = 1'b1;
				mm_a     = q_q;
				mm_b     = rd_b;
			end
			default: ;
		endcase
	end

	gpg_coef_ram #(.DEPTH(DEPTH), .AW(IDX_W), .W(W)) u_ram0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr0),
		.rdata (rd0)
	);

	gpg_coef_ram #(.DEPTH(DEPTH), .AW(IDX_W), .W(W)) u_ram1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr1),
		.rdata (rd1)
	);

	gpg_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.op_a   (mm_a),
		.op_b   (mm_b),
		.modp   (p_eff),
		.done   (mm_done),
		.result (mm_res)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			mod_q       <= gpg_pkg::MOD_RESET;
			idx_q       <= '0;
			da_q        <= '0;
			db_q        <= '0;
			k_q         <= '0;
			j_q         <= '0;
			ld_idx_q    <= '0;
			rem_deg_q   <= '0;
			asel_q      <= 1'b0;
			fin_q       <= 1'b0;
			err_q       <= 1'b0;
			anz_q       <= 1'b0;
			bnz_q       <= 1'b0;
			rem_nz_q    <= 1'b0;
			ld_sel_q    <= 1'b0;
			ld_eol_q    <= 1'b0;
			tmp_q       <= '0;
			q_q         <= '0;
			inv_q       <= '0;
			acc_q       <= '0;
			base_q      <= '0;
			e_q         <= '0;
			out_valid_q <= 1'b0;
			out_index   <= '0;
			out_value   <= '0;
			last        <= 1'b0;
			error       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mod_q <= cfg_wr_data;
			end
			// drop the output item once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && (state_q != S_OUT_PUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					asel_q <= 1'b0;
					err_q  <= 1'b0;
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_LOAD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_LOAD: begin
					if (in_take) begin
						ld_sel_q <= poly_select;
						ld_idx_q <= coef_index[IDX_W-1:0];
						ld_eol_q <= end_of_load;
						if (in_rng) begin
							state_q <= S_LMUL;
						end else if (end_of_load) begin
							idx_q   <= '0;
							anz_q   <= 1'b0;
							bnz_q   <= 1'b0;
							da_q    <= '0;
							db_q    <= '0;
							state_q <= S_PRD;
						end
					end
				end
				S_LMUL: begin
					if (mm_done) begin
						if (ld_eol_q) begin
							idx_q   <= '0;
							anz_q   <= 1'b0;
							bnz_q   <= 1'b0;
							da_q    <= '0;
							db_q    <= '0;
							state_q <= S_PRD;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				// reduce both stores mod p and find the degrees
				S_PRD: begin
					state_q <= S_PMA;
				end
				S_PMA: begin
					tmp_q   <= rd_b;
					state_q <= S_PWA;
				end
				S_PWA: begin
					if (mm_done) begin
						if (mm_res != '0) begin
							da_q  <= idx_q;
							anz_q <= 1'b1;
						end
						state_q <= S_PWB;
					end
				end
				S_PWB: begin
					if (mm_done) begin
						if (mm_res != '0) begin
							db_q  <= idx_q;
							bnz_q <= 1'b1;
						end
						if (idx_q == LAST_IDX) begin
							state_q <= S_DECIDE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_PRD;
						end
					end
				end
				// order the pair so that A has the larger degree
				S_DECIDE: begin
					if (!anz_q && !bnz_q) begin
						err_q   <= 1'b1;
						state_q <= S_OUT_PUT;
					end else begin
						if ((da_q < db_q) || !anz_q) begin
							asel_q <= ~asel_q;
							da_q   <= db_q;
							db_q   <= da_q;
							anz_q  <= bnz_q;
							bnz_q  <= anz_q;
						end
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					fin_q     <= !bnz_q;
					rem_nz_q  <= 1'b0;
					rem_deg_q <= '0;
					state_q   <= S_INV_RD;
				end
				// inverse of the leading coefficient by square and multiply
				S_INV_RD: begin
					state_q <= S_INV_LD;
				end
				S_INV_LD: begin
					base_q <= fin_q ? rd_a : rd_b;
					acc_q  <= W'(1);
					e_q    <= p_eff - W'(2);
					if (p_eff == gpg_pkg::MOD_MIN) begin
						state_q <= S_INV_END;
					end else begin
						state_q <= S_INV_CHK;
					end
				end
				S_INV_CHK: begin
					state_q <= e_q[0] ? S_INV_WACC : S_INV_WSQ;
				end
				S_INV_WACC: begin
					if (mm_done) begin
						acc_q   <= mm_res;
						state_q <= S_INV_WSQ;
					end
				end
				S_INV_WSQ: begin
					if (mm_done) begin
						base_q <= mm_res;
						e_q    <= e_q >> 1;
						if (e_q[W-1:1] == '0) begin
							state_q <= S_INV_END;
						end else begin
							state_q <= S_INV_CHK;
						end
					end
				end
				S_INV_END: begin
					inv_q <= acc_q;
					if (fin_q) begin
						idx_q   <= '0;
						state_q <= S_OUT_RD;
					end else begin
						k_q     <= da_q - db_q;
						state_q <= S_DIV_TOP;
					end
				end
				// one quotient digit per k, from the top down
				S_DIV_TOP: begin
					state_q <= (db_q == '0) ? S_DIV_END : S_DIV_Q;
				end
				S_DIV_Q: begin
					state_q <= S_DIV_QW;
				end
				S_DIV_QW: begin
					if (mm_done) begin
						q_q     <= mm_res;
						j_q     <= db_q + k_q - 1'b1;
						state_q <= S_DIV_RD;
					end
				end
				S_DIV_RD: begin
					state_q <= S_DIV_M;
				end
				S_DIV_M: begin
					tmp_q   <= rd_a;
					state_q <= S_DIV_MW;
				end
				S_DIV_MW: begin
					if (mm_done) begin
						// the last digit leaves the remainder: track its degree
						if ((k_q == '0) && (sub_res != '0) && !rem_nz_q) begin
							rem_deg_q <= j_q;
							rem_nz_q  <= 1'b1;
						end
						if (j_q == k_q) begin
							if (k_q == '0) begin
								state_q <= S_DIV_END;
							end else begin
								k_q     <= k_q - 1'b1;
								state_q <= S_DIV_TOP;
							end
						end else begin
							j_q     <= j_q - 1'b1;
							state_q <= S_DIV_RD;
						end
					end
				end
				// (A, B) becomes (B, remainder)
				S_DIV_END: begin
					asel_q  <= ~asel_q;
					da_q    <= db_q;
					db_q    <= rem_deg_q;
					bnz_q   <= rem_nz_q;
					state_q <= S_LOOP;
				end
				// scale the gcd to monic and emit it
				S_OUT_RD: begin
					state_q <= S_OUT_M;
				end
				S_OUT_M: begin
					state_q <= S_OUT_MW;
				end
				S_OUT_MW: begin
					if (mm_done) begin
						state_q <= S_OUT_PUT;
					end
				end
				S_OUT_PUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_index   <= err_q ? '0 : PW'(idx_q);
						out_value   <= err_q ? '0 : mm_res;
						last        <= out_last;
						error       <= err_q;
						if (out_last) begin
							idx_q   <= '0;
							state_q <= S_CLEAR;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

endmodule
